### hdl/mgs_pkg.sv
// ----------------------------------------------------------------------------
// Median grain size package
// Widths, stage payload types and shared constants of the D50 pipeline.
// ----------------------------------------------------------------------------
package mgs_pkg;

   localparam int NumClasses    = 6;
   localparam int FracWidth     = 16;
   localparam int DiamWidth     = 16;
   localparam int PairWidth     = FracWidth + 1;
   localparam int SumWidth      = FracWidth + 3;
   localparam int DiffWidth     = SumWidth + 2;
   localparam int OperWidth     = FracWidth + 1;
   localparam int ProdWidth     = DiamWidth + OperWidth;
   localparam int DenWidth      = SumWidth;
   localparam int QuoWidth      = 16;
   localparam int RemWidth      = DenWidth;
   localparam int CsrIndexWidth = 3;
   localparam int NumPairs      = NumClasses / 2;

   typedef logic [NumClasses-1:0][FracWidth-1:0] frac_array_type;
   typedef logic [NumClasses-1:0][DiamWidth-1:0] diam_array_type;
   typedef logic [NumClasses-1:0][SumWidth-1:0]  cum_array_type;
   typedef logic [NumPairs-1:0][PairWidth-1:0]   pair_array_type;

   typedef struct packed {
      logic                missing;
      logic                empty;
      logic                lead;
      logic                clip;
      logic [FracWidth-1:0] f0;
      logic [SumWidth-1:0]  total;
      logic [DiamWidth-1:0] lo;
      logic [DiamWidth-1:0] hi;
      logic [OperWidth-1:0] a;
      logic [OperWidth-1:0] b;
   } sel_type;

   typedef struct packed {
      logic                 missing;
      logic                 empty;
      logic                 clip;
      logic [ProdWidth-1:0] num;
      logic [DenWidth-1:0]  den;
   } div_in_type;

   typedef struct packed {
      logic                 missing;
      logic                 empty;
      logic                 clip;
      logic [ProdWidth-1:0] num;
      logic [DenWidth-1:0]  den;
      logic [RemWidth-1:0]  rem;
      logic [QuoWidth-1:0]  quo;
   } div_stage_type;

endpackage

### hdl/median_grain_size_interp.sv
// An accepted req passes the front, operand and divider stages to rsp_tvalid.
// Throughput: one cell per cycle; a full stage holds while the next stalls.
// Most of the depth is in the 16 one-bit stages of the restoring divider.
// Reset clears all stage valid bits and sets every class diameter to zero.
// ----------------------------------------------------------------------------
// Median grain size interpolation
// D50 of a grid cell from six class amounts, interpolated within the class
// where the running sum passes half the total.
// ----------------------------------------------------------------------------
module median_grain_size_interp
   import mgs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // tdata: frac_0 .. frac_5, 16 bits each, frac_0 in bits 15:0
   input  logic [NumClasses*FracWidth-1:0] req_tdata,
   // tuser: cell_missing
   input  logic                     req_tuser,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // tdata: median_size
   output logic [QuoWidth-1:0]      rsp_tdata,
   // tuser: result_missing
   output logic                     rsp_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [DiamWidth-1:0]     csr_data
);

   diam_array_type diam_ff;
   frac_array_type req_frac;
   sel_type        sel_data;
   logic           sel_valid, sel_ready;
   div_in_type     div_data;
   logic           div_valid, div_ready;

   assign csr_ready = 1'b1;
   assign req_frac  = req_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         diam_ff <= '0;
      end else if (csr_valid && csr_index < CsrIndexWidth'(NumClasses)) begin
         diam_ff[csr_index] <= csr_data;
      end
   end

   mgs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_missing (req_tuser),
      .in_frac    (req_frac),
      .diam       (diam_ff),
      .out_valid  (sel_valid),
      .out_ready  (sel_ready),
      .out_data   (sel_data)
   );

   mgs_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sel_valid),
      .in_ready  (sel_ready),
      .in_data   (sel_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   mgs_divide u_divide (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (div_valid),
      .in_ready    (div_ready),
      .in_data     (div_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_median  (rsp_tdata),
      .out_missing (rsp_tuser)
   );

endmodule

### hdl/mgs_front.sv
// ----------------------------------------------------------------------------
// Median grain size front end
// Three stages: pair sums, running sums, crossing class and operand select.
// ----------------------------------------------------------------------------
module mgs_front
   import mgs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic           in_missing,
   input  frac_array_type in_frac,
   input  diam_array_type diam,
   output logic           out_valid,
   input  logic           out_ready,
   output sel_type        out_data
);

   logic           v1_ff, v2_ff, v3_ff;
   logic           en1, en2, en3;
   logic           miss1_ff, miss2_ff;
   frac_array_type frac1_ff;
   pair_array_type pair1_in, pair1_ff;
   logic [FracWidth-1:0] f0_2_ff;
   cum_array_type  cum2_in, cum2_ff;
   sel_type        sel_in, sel_ff;

   logic signed [DiffWidth-1:0] diff [NumClasses];
   logic signed [DiffWidth-1:0] ndiff [NumClasses];
   logic [NumClasses-1:0]       crossed;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      for (int j = 0; j < NumPairs; j++) begin
         pair1_in[j] = {1'b0, in_frac[2*j]} + {1'b0, in_frac[2*j+1]};
      end
   end

   always_comb begin
      cum2_in[0] = SumWidth'(frac1_ff[0]);
      cum2_in[1] = SumWidth'(pair1_ff[0]);
      cum2_in[2] = SumWidth'(pair1_ff[0]) + SumWidth'(frac1_ff[2]);
      cum2_in[3] = SumWidth'(pair1_ff[0]) + SumWidth'(pair1_ff[1]);
      cum2_in[4] = SumWidth'(pair1_ff[0]) + SumWidth'(pair1_ff[1])
                 + SumWidth'(frac1_ff[4]);
      cum2_in[5] = SumWidth'(pair1_ff[0]) + SumWidth'(pair1_ff[1])
                 + SumWidth'(pair1_ff[2]);
   end

   always_comb begin
      for (int i = 0; i < NumClasses; i++) begin
         diff[i]    = $signed({1'b0, cum2_ff[i], 1'b0})
                    - $signed({2'b00, cum2_ff[NumClasses-1]});
         ndiff[i]   = -diff[i];
         crossed[i] = !diff[i][DiffWidth-1] && (diff[i] != '0);
      end
   end

   always_comb begin
      sel_in.missing = miss2_ff;
      sel_in.total   = cum2_ff[NumClasses-1];
      sel_in.f0      = f0_2_ff;
      sel_in.empty   = (cum2_ff[NumClasses-1] == '0);
      sel_in.lead    = crossed[0];
      sel_in.clip    = crossed[0] && (SumWidth'(f0_2_ff) == cum2_ff[NumClasses-1]);
      sel_in.a       = ndiff[NumClasses-2][OperWidth-1:0];
      sel_in.b       = diff[NumClasses-1][OperWidth-1:0];
      sel_in.lo      = diam[NumClasses-2];
      sel_in.hi      = diam[NumClasses-1];
      for (int i = NumClasses - 1; i >= 1; i--) begin
         if (crossed[i]) begin
            sel_in.a  = ndiff[i-1][OperWidth-1:0];
            sel_in.b  = diff[i][OperWidth-1:0];
            sel_in.lo = diam[i-1];
            sel_in.hi = diam[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         miss1_ff <= in_missing;
         frac1_ff <= in_frac;
         pair1_ff <= pair1_in;
      end
      if (en2 && v1_ff) begin
         miss2_ff <= miss1_ff;
         f0_2_ff  <= frac1_ff[0];
         cum2_ff  <= cum2_in;
      end
      if (en3 && v2_ff) begin
         sel_ff <= sel_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = sel_ff;

   assert property (@(posedge clock) disable iff (reset)
      v3_ff && !sel_ff.empty |-> sel_ff.b != '0)
      else $error("crossing class with zero width");

endmodule

### hdl/mgs_mult.sv
// ----------------------------------------------------------------------------
// Median grain size interpolation operands
// Two stages: weighted diameter products, then dividend and divisor.
// ----------------------------------------------------------------------------
module mgs_mult
   import mgs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  sel_type    in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output div_in_type out_data
);

   logic                  v1_ff, v2_ff;
   logic                  en1, en2;
   logic                  miss_ff, empty_ff, lead_ff, clip_ff;
   logic [FracWidth-1:0]  f0_ff;
   logic [SumWidth-1:0]   total_ff;
   logic [ProdWidth-1:0]  pl_in, pl_ff, ph_in, ph_ff;
   logic [OperWidth:0]    den_in, den_ff;
   div_in_type            div_in, div_ff;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   assign pl_in  = ProdWidth'(in_data.lo) * ProdWidth'(in_data.b);
   assign ph_in  = ProdWidth'(in_data.hi) * ProdWidth'(in_data.a);
   assign den_in = {1'b0, in_data.a} + {1'b0, in_data.b};

   always_comb begin
      div_in.missing = miss_ff;
      div_in.empty   = empty_ff;
      div_in.clip    = clip_ff;
      if (lead_ff) begin
         div_in.num = {1'b0, f0_ff, {QuoWidth{1'b0}}};
         div_in.den = total_ff;
      end else begin
         div_in.num = pl_ff + ph_ff;
         div_in.den = DenWidth'(den_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         miss_ff  <= in_data.missing;
         empty_ff <= in_data.empty;
         lead_ff  <= in_data.lead;
         clip_ff  <= in_data.clip;
         f0_ff    <= in_data.f0;
         total_ff <= in_data.total;
         pl_ff    <= pl_in;
         ph_ff    <= ph_in;
         den_ff   <= den_in;
      end
      if (en2 && v1_ff) begin
         div_ff <= div_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = div_ff;

   assert property (@(posedge clock) disable iff (reset)
      v2_ff && !div_ff.empty |-> div_ff.den != '0)
      else $error("zero divisor for nonzero total");

endmodule

### hdl/mgs_divide.sv
// ----------------------------------------------------------------------------
// Median grain size divider
// Restoring divider, one quotient bit per stage, with result select.
// ----------------------------------------------------------------------------
module mgs_divide
   import mgs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  div_in_type           in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [QuoWidth-1:0]  out_median,
   output logic                 out_missing
);

   localparam int Stages = QuoWidth;

   logic [Stages:0]   en;
   logic [Stages-1:0] v_ff;
   logic [Stages-1:0] src_v;
   div_stage_type     src [Stages];
   div_stage_type     st_in [Stages];
   div_stage_type     st_ff [Stages];

   assign en[Stages] = out_ready;
   assign in_ready   = en[0];

   always_comb begin
      src[0].missing = in_data.missing;
      src[0].empty   = in_data.empty;
      src[0].clip    = in_data.clip;
      src[0].num     = in_data.num;
      src[0].den     = in_data.den;
      src[0].rem     = RemWidth'(in_data.num[ProdWidth-1:QuoWidth]);
      src[0].quo     = '0;
   end
   assign src_v[0] = in_valid;

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      localparam int Bit = QuoWidth - 1 - s;
      logic [RemWidth:0] shifted;
      logic              ge;

      if (s > 0) begin : g_link
         assign src[s]   = st_ff[s-1];
         assign src_v[s] = v_ff[s-1];
      end

      assign en[s]   = !v_ff[s] || en[s+1];
      assign shifted = {src[s].rem, src[s].num[Bit]};
      assign ge      = (shifted >= {1'b0, src[s].den});

      always_comb begin
         st_in[s] = src[s];
         st_in[s].quo[Bit] = ge;
         if (ge) begin
            st_in[s].rem = RemWidth'(shifted - {1'b0, src[s].den});
         end else begin
            st_in[s].rem = shifted[RemWidth-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en[s]) begin
            v_ff[s] <= src_v[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en[s] && src_v[s]) begin
            st_ff[s] <= st_in[s];
         end
      end

      assert property (@(posedge clock) disable iff (reset)
         v_ff[s] && !st_ff[s].missing && !st_ff[s].empty && !st_ff[s].clip
         |-> st_ff[s].rem < st_ff[s].den)
         else $error("divider remainder out of range");
   end

   always_comb begin
      if (st_ff[Stages-1].missing || st_ff[Stages-1].empty) begin
         out_median = '0;
      end else if (st_ff[Stages-1].clip) begin
         out_median = '1;
      end else begin
         out_median = st_ff[Stages-1].quo;
      end
   end

   assign out_valid   = v_ff[Stages-1];
   assign out_missing = st_ff[Stages-1].missing;

endmodule
